>>> hw/rtl/wata_pkg.sv
// ---------------------------------------------------------------------------
// wata_pkg: shared types and constants for the windowed average alert block
// Channel and register codes, reset limits, queue sizing and the record
// that travels from the window update stage to the averaging pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package wata_pkg;

    // Sensor channel codes carried on the input tuser.
    typedef enum logic [1:0] {
        CH_TEMPERATURE  = 2'd0,
        CH_HUMIDITY     = 2'd1,
        CH_PRESSURE     = 2'd2,
        CH_UNRECOGNISED = 2'd3
    } channel_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_TEMPERATURE_LIMIT = 2'd0,
        REG_HUMIDITY_LIMIT    = 2'd1,
        REG_PRESSURE_LIMIT    = 2'd2
    } reg_index_t;

    localparam int NUM_CHANNELS = 3;

    // Reset thresholds in signed Q16.16: 28.0, 80.0 and 1015.0.
    localparam logic signed [31:0] TEMPERATURE_LIMIT_RESET = 32'sd1835008;
    localparam logic signed [31:0] HUMIDITY_LIMIT_RESET    = 32'sd5242880;
    localparam logic signed [31:0] PRESSURE_LIMIT_RESET    = 32'sd66519040;

    // Queue between the window update stage and the averaging pipeline.
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_LEVEL_W = $clog2(QUEUE_DEPTH + 1);

    // Quotient bits resolved by each stage of the averaging divider.
    localparam int DIV_STEP = 4;

    // Result fields that pass the divider untouched.
    typedef struct packed {
        logic        alert;
        logic        ignored;
        logic [1:0]  channel;
        logic [47:0] stamp;
    } side_t;

endpackage

`default_nettype wire

>>> hw/rtl/wata_front.sv
// ---------------------------------------------------------------------------
// wata_front: input stage with per-channel windows and running sums
// Accepts one item per cycle while the queue has room, replaces the oldest window
// entry of its channel, keeps the running sum and fill count, and decides the alert.
// ---------------------------------------------------------------------------
`default_nettype none

module wata_front #(
    parameter int WINDOW_LEN = 5,
    parameter int SUM_W      = 35,
    parameter int FILL_W     = 3
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [79:0]                      s_tdata,  // reading[31:0], stamp_ms[79:32]
    input  wire logic [1:0]                       s_tuser,  // channel[1:0]
    // Configuration writes
    input  wire logic                             cfg_we,
    input  wire logic [1:0]                       cfg_index,
    input  wire logic [31:0]                      cfg_data,
    // Queue side
    input  wire logic [wata_pkg::QUEUE_LEVEL_W-1:0] queue_level,
    output logic                                  push,
    output wata_pkg::side_t                       push_side,
    output logic signed [SUM_W-1:0]               push_sum,
    output logic [FILL_W-1:0]                     push_fill
);
    import wata_pkg::*;

    localparam int POS_W       = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int STORE_DEPTH = NUM_CHANNELS * WINDOW_LEN;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic signed [SUM_W-1:0] WLEN_S = SUM_W'(WINDOW_LEN);

    // Window entries of all channels, one row per channel.
    logic signed [31:0]       store_mem [STORE_DEPTH];

    // Per-channel state.
    logic signed [SUM_W-1:0]  sum_reg [NUM_CHANNELS];
    logic [FILL_W-1:0]        fill_reg [NUM_CHANNELS];
    logic [POS_W-1:0]         pos_reg [NUM_CHANNELS];
    logic signed [SUM_W-1:0]  limit_scaled_reg [NUM_CHANNELS];

    // Second stage: the accepted item and the entry it evicts.
    logic                     b_valid_reg;
    logic [1:0]               b_ch_reg;
    logic                     b_ignored_reg;
    logic signed [31:0]       b_reading_reg;
    logic [47:0]              b_stamp_reg;
    logic                     b_evict_reg;
    logic [FILL_W-1:0]        b_fill_reg;
    logic signed [31:0]       evict_data_reg;

    logic                     accept;
    logic [1:0]               ch_in;
    logic                     ignored_in;
    logic [1:0]               ch_idx;
    logic [POS_W-1:0]         pos_cur;
    logic [FILL_W-1:0]        fill_cur;
    logic                     full_cur;
    logic [ADDR_W-1:0]        slot;
    logic signed [31:0]       reading_in;
    logic signed [SUM_W-1:0]  cfg_scaled;
    logic signed [SUM_W-1:0]  sum_old;
    logic signed [SUM_W-1:0]  evict_ext;
    logic signed [SUM_W-1:0]  sum_next;
    logic                     full_next;
    logic                     alert_next;

    // Credit check: room for the item in flight and the new one.
    assign s_tready = ((QUEUE_LEVEL_W + 1)'(queue_level) + (QUEUE_LEVEL_W + 1)'(b_valid_reg))
                      < (QUEUE_LEVEL_W + 1)'(QUEUE_DEPTH);
    assign accept   = s_tvalid && s_tready;

    // Classify the item and locate the slot it overwrites.
    always_comb
    begin
        ch_in      = s_tuser;
        ignored_in = (ch_in == CH_UNRECOGNISED);
        ch_idx     = ignored_in ? CH_TEMPERATURE : ch_in;
        reading_in = signed'(s_tdata[31:0]);
        pos_cur    = pos_reg[ch_idx];
        fill_cur   = fill_reg[ch_idx];
        full_cur   = (fill_cur == FILL_W'(WINDOW_LEN));
        slot       = ADDR_W'(32'(ch_idx) * WINDOW_LEN + 32'(pos_cur));
    end

    // Threshold times window length, formed once when written.
    assign cfg_scaled = SUM_W'(signed'(cfg_data)) * WLEN_S;

    // Window memory: read-first, so the evicted entry comes out as it is replaced.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            evict_data_reg <= store_mem[slot];
            if (!ignored_in)
            begin
                store_mem[slot] <= reading_in;
            end
        end
    end

    // Second stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_ch_reg      <= ch_idx;
            b_ignored_reg <= ignored_in;
            b_reading_reg <= reading_in;
            b_stamp_reg   <= s_tdata[79:32];
            b_evict_reg   <= full_cur;
            b_fill_reg    <= full_cur ? fill_cur : fill_cur + FILL_W'(1);
        end
    end

    // Running sum update and threshold compare.
    always_comb
    begin
        sum_old    = sum_reg[b_ch_reg];
        evict_ext  = b_evict_reg ? SUM_W'(evict_data_reg) : '0;
        sum_next   = sum_old + SUM_W'(b_reading_reg) - evict_ext;
        full_next  = (b_fill_reg == FILL_W'(WINDOW_LEN));
        alert_next = !b_ignored_reg && full_next &&
                     (sum_next > limit_scaled_reg[b_ch_reg]);
    end

    assign push              = b_valid_reg;
    assign push_side.alert   = alert_next;
    assign push_side.ignored = b_ignored_reg;
    assign push_side.channel = b_ch_reg;
    assign push_side.stamp   = b_stamp_reg;
    assign push_sum          = b_ignored_reg ? '0 : sum_next;
    assign push_fill         = b_ignored_reg ? FILL_W'(1) : b_fill_reg;

    // Control state, per-channel counters and thresholds.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                sum_reg[i]  <= '0;
                fill_reg[i] <= '0;
                pos_reg[i]  <= '0;
            end
            limit_scaled_reg[CH_TEMPERATURE] <= SUM_W'(TEMPERATURE_LIMIT_RESET) * WLEN_S;
            limit_scaled_reg[CH_HUMIDITY]    <= SUM_W'(HUMIDITY_LIMIT_RESET) * WLEN_S;
            limit_scaled_reg[CH_PRESSURE]    <= SUM_W'(PRESSURE_LIMIT_RESET) * WLEN_S;
        end
        else
        begin
            b_valid_reg <= accept;

            if (accept && !ignored_in)
            begin
                fill_reg[ch_idx] <= full_cur ? fill_cur : fill_cur + FILL_W'(1);
                pos_reg[ch_idx]  <= (pos_cur == POS_W'(WINDOW_LEN - 1)) ? '0
                                                                       : pos_cur + POS_W'(1);
            end

            if (b_valid_reg && !b_ignored_reg)
            begin
                sum_reg[b_ch_reg] <= sum_next;
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TEMPERATURE_LIMIT: limit_scaled_reg[CH_TEMPERATURE] <= cfg_scaled;
                    REG_HUMIDITY_LIMIT:    limit_scaled_reg[CH_HUMIDITY]    <= cfg_scaled;
                    REG_PRESSURE_LIMIT:    limit_scaled_reg[CH_PRESSURE]    <= cfg_scaled;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/wata_queue.sv
// ---------------------------------------------------------------------------
// wata_queue: short first-in first-out queue between the two halves
// Holds window update records so that the front and the averaging
// pipeline stall independently. Reports its fill level for credit.
// ---------------------------------------------------------------------------
`default_nettype none

module wata_queue #(
    parameter int WIDTH = 88
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    input  wire logic [WIDTH-1:0]                   push_data,
    output logic [wata_pkg::QUEUE_LEVEL_W-1:0]      level,
    output logic                                    pop_valid,
    input  wire logic                               pop_ready,
    output logic [WIDTH-1:0]                        pop_data
);
    import wata_pkg::*;

    logic [WIDTH-1:0]         entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_LEVEL_W-1:0] count_reg;
    logic [QUEUE_LEVEL_W-1:0] count_next;
    logic                     pop;

    assign level     = count_reg;
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign pop       = pop_valid && pop_ready;

    // Level follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_LEVEL_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_LEVEL_W'(1);
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + QUEUE_PTR_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/wata_div.sv
// ---------------------------------------------------------------------------
// wata_div: pipelined averaging divider with output register
// Divides the signed running sum by the fill count, truncating toward
// zero, DIV_STEP quotient bits per stage, and presents the result item.
// ---------------------------------------------------------------------------
`default_nettype none

module wata_div #(
    parameter int SUM_W  = 35,
    parameter int FILL_W = 3
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire wata_pkg::side_t          in_side,
    input  wire logic signed [SUM_W-1:0]  in_sum,
    input  wire logic [FILL_W-1:0]        in_fill,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [79:0]                   m_tdata,  // window_mean[31:0], alert_stamp_ms[79:32]
    output logic [3:0]                    m_tuser   // alert[0], ignored[1], alert_channel[3:2]
);
    import wata_pkg::*;

    localparam int NUM_STAGES = (SUM_W + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_W      = NUM_STAGES * DIV_STEP;

    // Stage 0 holds the magnitude; stage k has resolved k * DIV_STEP bits.
    logic                 valid_reg [NUM_STAGES + 1];
    logic [DIV_W-1:0]     q_reg     [NUM_STAGES + 1];
    logic [FILL_W-1:0]    rem_reg   [NUM_STAGES + 1];
    logic [FILL_W-1:0]    d_reg     [NUM_STAGES + 1];
    logic                 neg_reg   [NUM_STAGES + 1];
    side_t                side_reg  [NUM_STAGES + 1];

    logic [DIV_W-1:0]     q_step    [1:NUM_STAGES];
    logic [FILL_W-1:0]    rem_step  [1:NUM_STAGES];

    logic                 out_valid_reg;
    side_t                out_side_reg;
    logic [31:0]          out_mean_reg;

    logic                 advance;
    logic                 in_neg;
    logic [SUM_W-1:0]     in_mag;

    // The whole pipeline moves whenever the output slot is free or taken.
    assign advance  = !out_valid_reg || m_tready;
    assign in_ready = advance;

    assign in_neg = in_sum[SUM_W-1];
    assign in_mag = in_neg ? -in_sum : in_sum;

    // Restoring division steps, DIV_STEP of them per stage.
    for (genvar k = 1; k <= NUM_STAGES; k++)
    begin : g_stage
        logic [FILL_W-1:0] rem_c;
        logic [DIV_W-1:0]  q_c;
        logic [FILL_W:0]   trial;
        logic              q_bit;

        always_comb
        begin
            rem_c = rem_reg[k-1];
            q_c   = q_reg[k-1];
            trial = '0;
            q_bit = 1'b0;
            for (int j = 0; j < DIV_STEP; j++)
            begin
                trial = {rem_c, q_c[DIV_W-1]};
                q_bit = (trial >= {1'b0, d_reg[k-1]});
                if (q_bit)
                begin
                    trial = trial - {1'b0, d_reg[k-1]};
                end
                rem_c = trial[FILL_W-1:0];
                q_c   = {q_c[DIV_W-2:0], q_bit};
            end
            q_step[k]   = q_c;
            rem_step[k] = rem_c;
        end
    end

    // Stage payload, moved on every advance.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            q_reg[0]    <= DIV_W'(in_mag);
            rem_reg[0]  <= '0;
            d_reg[0]    <= in_fill;
            neg_reg[0]  <= in_neg;
            side_reg[0] <= in_side;
            for (int k = 1; k <= NUM_STAGES; k++)
            begin
                q_reg[k]    <= q_step[k];
                rem_reg[k]  <= rem_step[k];
                d_reg[k]    <= d_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
            out_mean_reg <= neg_reg[NUM_STAGES] ? -q_reg[NUM_STAGES][31:0]
                                                : q_reg[NUM_STAGES][31:0];
            out_side_reg <= side_reg[NUM_STAGES];
        end
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NUM_STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k <= NUM_STAGES; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
            out_valid_reg <= valid_reg[NUM_STAGES];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_side_reg.stamp, out_mean_reg};
    assign m_tuser  = {out_side_reg.channel, out_side_reg.ignored, out_side_reg.alert};

endmodule

`default_nettype wire

>>> hw/rtl/windowed_average_threshold_alert.sv
// ---------------------------------------------------------------------------
// windowed_average_threshold_alert: moving average threshold detector
// Per-channel sliding windows of signed Q16.16 samples with alerting when
// the full-window average exceeds the channel threshold.
// ---------------------------------------------------------------------------
// The block takes one item per clock cycle while its queue has room, and
// returns one result item for every item, in order. Each of the three
// channels keeps its last WINDOW_LEN readings in a read-first window
// memory; the entry being replaced is read in the same cycle as the new
// reading is written, and the running sum is corrected in the following
// cycle. A result carries the average (sum over fill count, truncated
// toward zero), the alert flag and the timestamp; items on the
// unrecognised channel change nothing and return a flagged result. Each
// result passes the second front stage, the queue, the pipelined divider,
// which resolves four quotient bits per stage, and the output register. A
// four-entry queue decouples the input from the divider so that output
// stalls do not stop input acceptance at once. Thresholds may be written
// only while no item is in flight.
`default_nettype none

module windowed_average_threshold_alert #(
    parameter int WINDOW_LEN = 5
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [79:0]  s_tdata,   // reading[31:0], stamp_ms[79:32]
    input  wire logic [1:0]   s_tuser,   // channel[1:0]
    // Result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [79:0]       m_tdata,   // window_mean[31:0], alert_stamp_ms[79:32]
    output logic [3:0]        m_tuser,   // alert[0], ignored[1], alert_channel[3:2]
    // Configuration writes
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);
    import wata_pkg::*;

    localparam int SUM_W   = 32 + $clog2(WINDOW_LEN);
    localparam int FILL_W  = $clog2(WINDOW_LEN + 1);
    localparam int REC_W   = $bits(side_t) + SUM_W + FILL_W;

    logic                       push;
    side_t                      push_side;
    logic signed [SUM_W-1:0]    push_sum;
    logic [FILL_W-1:0]          push_fill;
    logic [QUEUE_LEVEL_W-1:0]   queue_level;
    logic                       pop_valid;
    logic                       pop_ready;
    logic [REC_W-1:0]           pop_data;
    side_t                      pop_side;
    logic signed [SUM_W-1:0]    pop_sum;
    logic [FILL_W-1:0]          pop_fill;

    // Window update and alert decision.
    wata_front #(
        .WINDOW_LEN (WINDOW_LEN),
        .SUM_W      (SUM_W),
        .FILL_W     (FILL_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .queue_level (queue_level),
        .push        (push),
        .push_side   (push_side),
        .push_sum    (push_sum),
        .push_fill   (push_fill)
    );

    // Record queue between the two halves.
    wata_queue #(
        .WIDTH (REC_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_side, push_sum, push_fill}),
        .level     (queue_level),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data)
    );

    assign {pop_side, pop_sum, pop_fill} = pop_data;

    // Averaging divider and result register.
    wata_div #(
        .SUM_W  (SUM_W),
        .FILL_W (FILL_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pop_valid),
        .in_ready (pop_ready),
        .in_side  (pop_side),
        .in_sum   (pop_sum),
        .in_fill  (pop_fill),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

>>> bench/windowed_average_threshold_alert_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// windowed_average_threshold_alert_test: self-checking bench for the block
// Streams tagged samples through the windowed average detector and checks
// every result item against a local model of the per-channel windows, sums
// and thresholds. Directed items cover the boundaries; random traffic with
// changing thresholds, random idling and back-pressure covers the rest.
// ---------------------------------------------------------------------------
module windowed_average_threshold_alert_test;

    import wata_pkg::*;

    localparam int WINDOW        = 5;
    localparam int SETTLE_CYCLES = 20;
    localparam int QUIET_LIMIT   = 1000;
    localparam int HOLD_CYCLES   = 300;

    // Index beyond the register file; writes to it must be dropped.
    localparam logic [1:0] REG_OUT_OF_RANGE = 2'd3;

    // Fields of one result item.
    typedef struct {
        logic              alert;
        logic              ignored;
        logic [1:0]        channel;
        logic signed [31:0] mean;
        logic [47:0]       stamp;
    } result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata   = '0;     // reading[31:0], stamp_ms[79:32]
    logic [1:0]  s_tuser   = '0;     // channel[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [79:0] m_tdata;            // window_mean[31:0], alert_stamp_ms[79:32]
    logic [3:0]  m_tuser;            // alert[0], ignored[1], alert_channel[3:2]
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    // Local copy of the block's state and thresholds.
    logic signed [31:0] window_copy [NUM_CHANNELS][WINDOW] = '{default: '0};
    longint             channel_sum [NUM_CHANNELS] = '{default: 0};
    int                 fill_level  [NUM_CHANNELS] = '{default: 0};
    int                 next_slot   [NUM_CHANNELS] = '{default: 0};
    longint             limit_copy  [NUM_CHANNELS] = '{
        longint'(TEMPERATURE_LIMIT_RESET),
        longint'(HUMIDITY_LIMIT_RESET),
        longint'(PRESSURE_LIMIT_RESET)
    };

    result_t expected_results [$];

    // Idling controls shared between the stimulus and the receiver.
    bit tx_gaps_on   = 1'b1;
    bit rx_stalls_on = 1'b1;
    int rx_hold_left = 0;

    int error_count     = 0;
    int items_sent      = 0;
    int ignored_sent    = 0;
    int results_checked = 0;
    int alerts_seen     = 0;

    windowed_average_threshold_alert #(
        .WINDOW_LEN (WINDOW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(string msg);
        error_count++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    // Offers one sample, waits for acceptance and records its expected result.
    task automatic send_sample(channel_t ch, logic [31:0] reading, logic [47:0] stamp);
        result_t want;
        int      idx;
        longint  quotient;
        if (tx_gaps_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {stamp, reading};
        s_tuser  <= ch;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;

        want.stamp = stamp;
        if (ch == CH_UNRECOGNISED)
        begin
            // Nothing changes; a flagged, zeroed result comes back.
            ignored_sent++;
            want.alert   = 1'b0;
            want.ignored = 1'b1;
            want.channel = CH_TEMPERATURE;
            want.mean    = '0;
        end
        else
        begin
            // Append while filling, otherwise replace the oldest entry.
            idx = int'(ch);
            if (fill_level[idx] < WINDOW)
                fill_level[idx]++;
            else
                channel_sum[idx] -= longint'(window_copy[idx][next_slot[idx]]);
            window_copy[idx][next_slot[idx]] = reading;
            channel_sum[idx] += longint'($signed(reading));
            next_slot[idx] = (next_slot[idx] + 1) % WINDOW;

            quotient     = channel_sum[idx] / longint'(fill_level[idx]);
            want.alert   = (fill_level[idx] == WINDOW) &&
                           (channel_sum[idx] > limit_copy[idx] * WINDOW);
            want.ignored = 1'b0;
            want.channel = ch;
            want.mean    = quotient[31:0];
        end
        expected_results.push_back(want);
    endtask

    // Writes one threshold register; the block must be idle.
    task automatic write_limit(logic [1:0] idx, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx < NUM_CHANNELS)
            limit_copy[idx] = longint'($signed(value));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Stops offering items until every expected result has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic channel_t pick_channel();
        int unsigned sel;
        sel = $urandom_range(0, 11);
        return (sel == 11) ? CH_UNRECOGNISED : channel_t'(sel % 3);
    endfunction

    // Readings cluster around the threshold so alerts come and go.
    function automatic logic [31:0] pick_reading(logic [31:0] centre);
        int unsigned sel;
        int          span;
        int          offset;
        sel = $urandom_range(0, 9);
        if (sel < 6)
        begin
            case ($urandom_range(0, 2))
                0:       span = 3;
                1:       span = 255;
                default: span = 65535;
            endcase
            offset = int'($urandom_range(0, 2 * span)) - span;
            return centre + offset;
        end
        else if (sel < 8)
            return $urandom;
        else if (sel == 8)
            return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        else
            return 32'(int'($urandom_range(0, 15)) - 8);
    endfunction

    function automatic logic [31:0] pick_limit();
        int unsigned sel;
        int          whole;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 32'h7FFF_FFFF;
        else if (sel == 1)
            return 32'h8000_0000;
        else if (sel < 5)
            return $urandom;
        whole = int'($urandom_range(0, 2047)) - 1024;
        return 32'(whole <<< 16) + $urandom_range(0, 65535);
    endfunction

    function automatic logic [47:0] pick_stamp();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[47:0];
    endfunction

    // Boundaries under the reset thresholds: partial windows, the exact
    // equality compare, truncation toward zero and the extreme readings.
    task automatic test_reset_thresholds();
        int n;
        send_sample(CH_UNRECOGNISED, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF);
        for (n = 0; n < 5; n++)
            send_sample(CH_TEMPERATURE, TEMPERATURE_LIMIT_RESET, 48'(n + 1));
        send_sample(CH_TEMPERATURE, TEMPERATURE_LIMIT_RESET + 1, 48'd6);
        send_sample(CH_HUMIDITY, 32'hFFFF_FFF9, 48'd7);
        send_sample(CH_HUMIDITY, 32'h0000_0000, 48'd8);
        for (n = 0; n < 5; n++)
            send_sample(CH_PRESSURE, 32'h7FFF_FFFF, 48'h0);
        for (n = 0; n < 5; n++)
            send_sample(CH_PRESSURE, 32'h8000_0000, 48'hFFFF_FFFF_FFFF);
    endtask

    // Thresholds at their extremes, and a write to the unused index.
    task automatic test_threshold_extremes();
        wait_for_results();
        write_limit(REG_PRESSURE_LIMIT, 32'h8000_0000);
        send_sample(CH_PRESSURE, 32'h8000_0000, 48'h0000_0000_1000);
        send_sample(CH_PRESSURE, 32'h8000_0001, 48'h0000_0000_1001);
        wait_for_results();
        write_limit(REG_TEMPERATURE_LIMIT, 32'h7FFF_FFFF);
        send_sample(CH_TEMPERATURE, 32'h7FFF_FFFF, 48'h0000_0000_1002);
        wait_for_results();
        write_limit(REG_OUT_OF_RANGE, 32'h0000_0000);
        write_limit(REG_HUMIDITY_LIMIT, 32'hFFFF_FFFF);
        send_sample(CH_HUMIDITY, 32'h0000_0000, 48'h0000_0000_1003);
        send_sample(CH_HUMIDITY, 32'h0000_0000, 48'h0000_0000_1004);
        send_sample(CH_HUMIDITY, 32'h0000_0003, 48'h0000_0000_1005);
    endtask

    // Random traffic in phases, with fresh thresholds for each phase.
    task automatic test_random_traffic();
        int       phase;
        int       n;
        channel_t ch;
        for (phase = 0; phase < 10; phase++)
        begin
            wait_for_results();
            write_limit(REG_TEMPERATURE_LIMIT, pick_limit());
            write_limit(REG_HUMIDITY_LIMIT, pick_limit());
            write_limit(REG_PRESSURE_LIMIT, pick_limit());
            if ($urandom_range(0, 2) == 0)
                write_limit(REG_OUT_OF_RANGE, $urandom);
            for (n = 0; n < 105; n++)
            begin
                ch = pick_channel();
                send_sample(ch,
                            pick_reading(ch == CH_UNRECOGNISED ? 32'h0 :
                                         limit_copy[int'(ch)][31:0]),
                            pick_stamp());
            end
        end
    endtask

    // The receiver holds off for a long stretch while items keep coming,
    // so the internal queue fills and the input stalls.
    task automatic test_output_backpressure();
        int       n;
        channel_t ch;
        rx_hold_left = HOLD_CYCLES;
        for (n = 0; n < 40; n++)
        begin
            ch = pick_channel();
            send_sample(ch, pick_reading(ch == CH_UNRECOGNISED ? 32'h0 :
                                         limit_copy[int'(ch)][31:0]),
                        pick_stamp());
        end
        wait_for_results();
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_full_rate();
        int       n;
        channel_t ch;
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        for (n = 0; n < 150; n++)
        begin
            ch = pick_channel();
            send_sample(ch, pick_reading(ch == CH_UNRECOGNISED ? 32'h0 :
                                         limit_copy[int'(ch)][31:0]),
                        pick_stamp());
        end
        wait_for_results();
    endtask

    // Main sequence.
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_thresholds();
        test_threshold_extremes();
        test_random_traffic();
        test_output_backpressure();
        test_full_rate();

        $display("Run covered %0d samples (%0d on the unrecognised channel), %0d results checked,",
                 items_sent, ignored_sent, results_checked);
        $display("%0d alerts, threshold changes incl. extremes, idling and a long output stall.",
                 alerts_seen);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Receiver: random stall bursts, plus a long hold when requested.
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_left > 0)
            begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (rx_stalls_on && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 19);
            end
        end
    end

    // Compares one accepted result item with the oldest expectation.
    task automatic check_result();
        result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("result item with none expected: tdata %h tuser %h",
                                      m_tdata, m_tuser));
        end
        else
        begin
            want = expected_results.pop_front();
            results_checked++;
            if (want.alert)
                alerts_seen++;
            if (m_tuser[0] !== want.alert)
                report_mismatch($sformatf("alert %b, expected %b (stamp %h)",
                                          m_tuser[0], want.alert, want.stamp));
            if (m_tuser[1] !== want.ignored)
                report_mismatch($sformatf("ignored %b, expected %b (stamp %h)",
                                          m_tuser[1], want.ignored, want.stamp));
            if (m_tuser[3:2] !== want.channel)
                report_mismatch($sformatf("channel %0d, expected %0d (stamp %h)",
                                          m_tuser[3:2], want.channel, want.stamp));
            if (m_tdata[31:0] !== want.mean)
                report_mismatch($sformatf("mean %h, expected %h (stamp %h)",
                                          m_tdata[31:0], want.mean, want.stamp));
            if (m_tdata[79:32] !== want.stamp)
                report_mismatch($sformatf("stamp %h, expected %h",
                                          m_tdata[79:32], want.stamp));
        end
    endtask

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result();
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/wata_pkg.sv
hw/rtl/wata_front.sv
hw/rtl/wata_queue.sv
hw/rtl/wata_div.sv
hw/rtl/windowed_average_threshold_alert.sv
bench/windowed_average_threshold_alert_test.sv
